@@ sv/tosc_pkg.sv @@
// Shared constants, types and helper functions for the triangle oscillator.
package tosc_pkg;

  localparam int DW                  = 32;
  localparam int FRAC_BITS_DEF       = 8;
  localparam int MAX_PHASE_STEPS_DEF = 8388608;
  localparam int SHIFT_W             = 5;

  // Request type carried by an input item.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // Handshake status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Value shift from max_value: s = ceil log2 (capped at 30), shift = 30 - s - 1, floor 0.
  function automatic logic [SHIFT_W-1:0] shift_for(input logic [30:0] mv);
    logic [SHIFT_W-1:0] s;
    logic [SHIFT_W-1:0] r;
    s = '0;
    for (int k = 0; k < 30; k++) begin
      if ({1'b0, mv} > (32'd1 << k)) begin
        s = s + SHIFT_W'(1);
      end
    end
    r = SHIFT_W'(30) - s;
    if (mv == '0) begin
      return '0;
    end
    return (r >= SHIFT_W'(1)) ? r - SHIFT_W'(1) : '0;
  endfunction

endpackage

@@ sv/tosc_div.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
module tosc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [tosc_pkg::DW-1:0]  a_i,
  input  logic signed [tosc_pkg::DW-1:0]  b_i,
  output logic signed [tosc_pkg::DW-1:0]  q_o,
  output tosc_pkg::div_sts_t              sts_o
);
  import tosc_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic          neg_q;
  logic          zero_q;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   diff;
  logic [DW-1:0] a_abs;
  logic [DW-1:0] b_abs;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign a_abs = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
  assign b_abs = b_i[DW-1] ? DW'(-b_i) : DW'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= a_abs;
      rem_q  <= '0;
      den_q  <= b_abs;
      neg_q  <= a_i[DW-1] ^ b_i[DW-1];
      zero_q <= (b_i == '0);
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign q_o        = zero_q ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

@@ sv/triangle_oscillator_retarget.sv @@
// Top level of the four-phase fixed-point triangle oscillator with retargeting.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in       | in        | in_valid_i/in_ready_o | req_type_i, delta_i, steps_i
//  out      | out       | out_valid_o/out_ready_i | level_o
//  cfg      | in        | cfg_we_i (no wait)    | cfg_wdata_i (max_value)
//
// A tick item updates the oscillator state, then the output register loads.
// A set item spends most of its time in up to three waits on the shared radix-2
// divider (32 quotient bits each), plus three steps on the shared multiplier.
// An unchanged or zero-length set item goes from the set state straight to output.
// Reset clears the oscillator state and the value shift; a max_value write clears
// the state and reloads the shift. A result waiting on out_ready_i holds the block in its output state.
module triangle_oscillator_retarget #(
  parameter int FRAC_BITS       = tosc_pkg::FRAC_BITS_DEF,
  parameter int MAX_PHASE_STEPS = tosc_pkg::MAX_PHASE_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic signed [30:0] delta_i,
  input  logic        [23:0] steps_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [30:0] level_o,
  input  logic               cfg_we_i,
  input  logic        [30:0] cfg_wdata_i
);
  import tosc_pkg::*;

  localparam logic signed [DW-1:0] HALF_LSB = DW'(1) << (FRAC_BITS - 1);
  localparam logic        [23:0]   MAX_N    = 24'(MAX_PHASE_STEPS);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SET      = 9'b000000010,
    ST_DIV_POS  = 9'b000000100,
    ST_MUL_POS  = 9'b000001000,
    ST_DIV_INC  = 9'b000010000,
    ST_DIV_BIAS = 9'b000100000,
    ST_MUL_BIAS = 9'b001000000,
    ST_MUL_VAL  = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Architectural oscillator state.
  logic [SHIFT_W-1:0]   shift_q;
  logic signed [DW-1:0] amp_q;
  logic        [23:0]   len_q;
  logic signed [DW-1:0] val_q;
  logic signed [DW-1:0] inc_q;
  logic signed [DW-1:0] bias_q;
  logic        [1:0]    phase_q;
  logic signed [DW-1:0] pos_q;

  // Set-item working registers.
  logic signed [DW-1:0] d_q;
  logic        [23:0]   n_q;
  logic signed [DW-1:0] wk_q;      // quotient t, then halved bias quotient
  logic signed [DW-1:0] pos_w_q;
  logic signed [DW-1:0] inc_w_q;
  logic signed [DW-1:0] bias_w_q;

  logic               out_valid_q;
  logic signed [30:0] level_q;

  // Shared units.
  logic                 div_start;
  logic signed [DW-1:0] div_a, div_b, div_q;
  div_sts_t             div_sts;
  logic signed [DW-1:0] mul_a, mul_b, mul_p;

  logic signed [DW-1:0] n32, len32, unscaled, d_in, sum_out, lvl, q_half;
  logic                 set_clear, set_same, unscaled_nz, out_free, tick_go;
  logic        [23:0]   n_in;

  assign n32         = {8'b0, n_q};
  assign len32       = {8'b0, len_q};
  assign unscaled    = d_q >>> shift_q;
  assign unscaled_nz = (unscaled != '0);
  assign set_clear   = (n_q == '0);
  assign set_same    = (n_q == len_q) && (d_q == amp_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign d_in        = DW'($signed({delta_i[30], delta_i})) <<< shift_q;
  assign n_in        = (steps_i > MAX_N) ? MAX_N : steps_i;
  assign tick_go     = pos_q < (len32 - DW'(1));
  // sdiv by 2 truncates toward zero
  assign q_half      = $signed(div_q + DW'(div_q[DW-1])) >>> 1;
  assign sum_out     = val_q + bias_q;
  assign lvl         = sum_out >>> shift_q;

  tosc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (div_a),
    .b_i    (div_b),
    .q_o    (div_q),
    .sts_o  (div_sts)
  );

  // Divider requests: position rescale, increment, rounding-bias quotient.
  always_comb begin
    div_start = 1'b0;
    div_a     = d_q;
    div_b     = n32;
    unique case (state_q)
      ST_SET: begin
        if (!set_clear && !set_same) begin
          div_start = 1'b1;
          if (len_q != '0) begin
            div_a = (pos_q <<< FRAC_BITS) + HALF_LSB;
            div_b = len32;
          end
        end
      end
      ST_MUL_POS: div_start = 1'b1;
      ST_DIV_INC: begin
        if (div_sts.done && unscaled_nz) begin
          div_start = 1'b1;
          div_a     = n32 <<< FRAC_BITS;
          div_b     = unscaled;
        end
      end
      default: ;
    endcase
  end

  // Shared multiplier operands; low 32 bits only.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL_POS: begin
        mul_a = wk_q;
        mul_b = n32;
      end
      ST_MUL_BIAS: begin
        mul_a = wk_q;
        mul_b = inc_w_q >>> FRAC_BITS;
      end
      ST_MUL_VAL: begin
        mul_a = phase_q[1] ? -inc_w_q : inc_w_q;
        mul_b = phase_q[0] ? (n32 - pos_w_q) : pos_w_q;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = (req_type_i == REQ_SET) ? ST_SET : ST_OUT;
      ST_SET: begin
        if (set_clear || set_same) state_d = ST_OUT;
        else if (len_q != '0)      state_d = ST_DIV_POS;
        else                       state_d = ST_DIV_INC;
      end
      ST_DIV_POS:  if (div_sts.done) state_d = ST_MUL_POS;
      ST_MUL_POS:  state_d = ST_DIV_INC;
      ST_DIV_INC:  if (div_sts.done) state_d = unscaled_nz ? ST_DIV_BIAS : ST_MUL_VAL;
      ST_DIV_BIAS: if (div_sts.done) state_d = ST_MUL_BIAS;
      ST_MUL_BIAS: state_d = ST_MUL_VAL;
      ST_MUL_VAL:  state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control and oscillator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      shift_q     <= '0;
      amp_q       <= '0;
      len_q       <= '0;
      val_q       <= '0;
      inc_q       <= '0;
      bias_q      <= '0;
      phase_q     <= '0;
      pos_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        // new max_value restarts the oscillator
        shift_q <= shift_for(cfg_wdata_i);
        amp_q   <= '0;
        len_q   <= '0;
        val_q   <= '0;
        inc_q   <= '0;
        bias_q  <= '0;
        phase_q <= '0;
        pos_q   <= '0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_valid_i && (req_type_i == REQ_TICK) && len_q != '0) begin
              if (tick_go) begin
                val_q <= val_q + inc_q;
                pos_q <= pos_q + DW'(1);
              end else begin
                // phase boundary: snap to the phase's start value
                phase_q <= phase_q + 2'd1;
                pos_q   <= '0;
                unique case (phase_q + 2'd1)
                  2'd0: val_q <= '0;
                  2'd1: begin
                    val_q <= amp_q;
                    inc_q <= -inc_q;
                  end
                  2'd2: val_q <= '0;
                  default: begin
                    val_q <= -amp_q;
                    inc_q <= -inc_q;
                  end
                endcase
              end
            end
          end
          ST_SET: begin
            if (set_clear) begin
              // zero length clears everything but the rounding bias
              amp_q   <= '0;
              len_q   <= '0;
              val_q   <= '0;
              inc_q   <= '0;
              phase_q <= '0;
              pos_q   <= '0;
            end
          end
          ST_MUL_VAL: begin
            amp_q  <= d_q;
            len_q  <= n_q;
            val_q  <= mul_p;
            inc_q  <= (phase_q == 2'd1 || phase_q == 2'd2) ? -inc_w_q : inc_w_q;
            bias_q <= bias_w_q;
            pos_q  <= pos_w_q;
          end
          default: ;
        endcase
      end
    end
  end

  // Set-item working registers and output payload.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        d_q <= d_in;
        n_q <= n_in;
      end
      ST_SET:      pos_w_q <= '0;
      ST_DIV_POS:  if (div_sts.done) wk_q <= div_q;
      ST_MUL_POS:  pos_w_q <= mul_p >>> FRAC_BITS;
      ST_DIV_INC: begin
        if (div_sts.done) begin
          inc_w_q <= div_q;
          if (!unscaled_nz) bias_w_q <= '0;
        end
      end
      ST_DIV_BIAS: if (div_sts.done) wk_q <= q_half;
      ST_MUL_BIAS: bias_w_q <= mul_p;
      ST_OUT:      if (out_free) level_q <= lvl[30:0];
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // A quotient only arrives while the sequencer waits for one.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV_POS || state_q == ST_DIV_INC ||
                      state_q == ST_DIV_BIAS))
    else $error("divider result with no consumer");

  // A max_value write leaves the oscillator cleared.
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (len_q == '0 && bias_q == '0 && phase_q == '0 && val_q == '0))
    else $error("state not cleared by max_value write");

  // A set item always occupies the sequencer past the accept cycle.
  a_set_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_SET)) |=> !in_ready_o)
    else $error("set item did not occupy the sequencer");

endmodule

@@ verif/triangle_oscillator_retarget_tb.sv @@
// Self-checking testbench for the retargeting triangle oscillator: random and directed items.
module triangle_oscillator_retarget_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tosc_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int MAX_STEPS = MAX_PHASE_STEPS_DEF;
  localparam int LIMIT     = 3_000_000;  // cycles before the run is declared hung
  localparam int CFG_GAP   = 8;          // quiet cycles ahead of a max_value write
  localparam int TAIL      = 150;        // quiet cycles at the end of the run
  localparam int HOLD_LEN  = 400;        // receiver hold-off, long enough to back up the input
  localparam int RAND_ITEMS = 290;       // per random block, seven blocks

  // Quarter of the triangle the oscillator is in.
  typedef enum bit [1:0] {PH_RISE, PH_FALL, PH_DIP, PH_RETURN} wave_phase_e;

  typedef struct {
    bit               kind;
    bit signed [30:0] delta;
    bit        [23:0] steps;
  } osc_req_t;

  // DUT ports; every input known from time zero.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = REQ_TICK;
  logic signed [30:0] delta_i = '0;
  logic        [23:0] steps_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [30:0] level_o;
  logic               cfg_we_i = 1'b0;
  logic        [30:0] cfg_wdata_i = '0;

  triangle_oscillator_retarget dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .delta_i     (delta_i),
    .steps_i     (steps_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Oscillator predictor. All words are 32-bit signed and wrap; shifts of an
  // int are arithmetic on the way right.
  // ---------------------------------------------------------------------------
  int unsigned shift_w;
  int          amp_w, len_w, val_w, inc_w, bias_w, pos_w;
  wave_phase_e ph_w;

  // Truncating divide on magnitudes; divide by zero gives zero and the most
  // negative word over -1 wraps back onto itself.
  function automatic int div_trunc(int a, int b);
    bit [31:0] ua, ub, q;
    bit        neg;
    if (b == 0) return 0;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    q   = ua / ub;
    return neg ? int'(-q) : int'(q);
  endfunction

  function automatic int sra(int a, int unsigned s);
    return a >>> (s & 31);
  endfunction

  // Value shift: smallest s (capped at 30) with 2^s >= max_value, then 29 - s.
  function automatic int unsigned shift_of(bit [30:0] mv);
    int unsigned s;
    s = 0;
    if (mv == '0) return 0;
    while ((64'd1 << s) < {33'd0, mv} && s < 30) s++;
    s = 30 - s;
    return (s >= 1) ? s - 1 : 0;
  endfunction

  function automatic void retarget(int d_in, int n_in);
    int d, n, p, step, v, unsc, b, t;
    d = d_in;
    n = n_in;
    b = 0;
    if (n > MAX_STEPS) n = MAX_STEPS;
    if (n <= 0) begin
      // cleared, but the rounding bias survives
      amp_w = 0; len_w = 0; val_w = 0; inc_w = 0; ph_w = PH_RISE; pos_w = 0;
      return;
    end
    d = d << shift_w;
    if (n == len_w && d == amp_w) return;
    // rescale the position inside the current phase, rounded
    p = 0;
    if (len_w != 0) begin
      t = (pos_w << FRAC) + (1 << (FRAC - 1));
      t = div_trunc(t, len_w);
      p = sra(t * n, FRAC);
    end
    step = div_trunc(d, n);
    unsc = sra(d, shift_w);
    if (unsc != 0) begin
      b = div_trunc(div_trunc(n << FRAC, unsc), 2);
      b = b * sra(step, FRAC);
    end
    case (ph_w)
      PH_RISE: v = step * p;
      PH_FALL: begin
        v    = step * (n - p);
        step = -step;
      end
      PH_DIP: begin
        v    = -step * p;
        step = -step;
      end
      default: v = -step * (n - p);
    endcase
    amp_w  = d;
    len_w  = n;
    val_w  = v;
    inc_w  = step;
    bias_w = b;
    pos_w  = p;
  endfunction

  function automatic void advance();
    if (len_w == 0) return;
    if (pos_w < len_w - 1) begin
      val_w = val_w + inc_w;
      pos_w = pos_w + 1;
      return;
    end
    ph_w = wave_phase_e'(2'(ph_w + 1));
    case (ph_w)
      PH_RISE: val_w = 0;
      PH_FALL: begin
        val_w = amp_w;
        inc_w = -inc_w;
      end
      PH_DIP: val_w = 0;
      default: begin
        val_w = -amp_w;
        inc_w = -inc_w;
      end
    endcase
    pos_w = 0;
  endfunction

  function automatic bit signed [30:0] osc_apply(bit kind, bit signed [30:0] dl, bit [23:0] st);
    if (kind == REQ_SET) retarget(int'(dl), int'(st));
    else advance();
    return 31'(sra(val_w + bias_w, shift_w));
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, idling knobs, error tally
  // ---------------------------------------------------------------------------
  osc_req_t         send_q[$];   // items not yet offered
  bit signed [30:0] level_q[$];  // predicted levels, oldest first
  int unsigned      send_idle_pct = 29;
  int unsigned      recv_idle_pct = 45;
  logic             hold_on = 1'b0;
  int               err_cnt = 0;
  int               cycles = 0;
  event             hold_go;

  function automatic void log_miss(string what, bit signed [30:0] exp_l, logic signed [30:0] act_l);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR %s: expected level %0d, got %0d", what, exp_l, act_l);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts on acceptance, then offers the next item unless idling.
  // Valid is only touched when the slot is free, so it never drops an offer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    osc_req_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        level_q.push_back(osc_apply(req_type_i, delta_i, steps_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = send_q.pop_front();
          req_type_i <= r.kind;
          delta_i    <= r.delta;
          steps_i    <= r.steps;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted level against the oldest prediction and
  // draws the next ready, forced low while a hold-off runs.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bit signed [30:0] exp_l;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (level_q.size() == 0) begin
          log_miss("unexpected item", '0, level_o);
        end else begin
          exp_l = level_q.pop_front();
          if (level_o !== exp_l) log_miss("level mismatch", exp_l, level_o);
        end
      end
      out_ready_i <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering.
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("triangle_oscillator_retarget verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_set(int d, int n);
    osc_req_t r;
    r.kind  = REQ_SET;
    r.delta = 31'(d);
    r.steps = 24'(n);
    send_q.push_back(r);
  endtask

  // Tick payload is don't-care; random bits keep every input line moving.
  task automatic push_tick();
    osc_req_t r;
    r.kind  = REQ_TICK;
    r.delta = 31'($urandom());
    r.steps = 24'($urandom());
    send_q.push_back(r);
  endtask

  // Wait until nothing is pending or in flight, then some quiet cycles.
  task automatic settle(int tail);
    do @(negedge clk_i);
    while (send_q.size() != 0 || in_valid_i || level_q.size() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  // A max_value write restarts the oscillator from zero.
  task automatic program_max(bit [30:0] mv);
    settle(CFG_GAP);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shift_w  = shift_of(mv);
    amp_w = 0; len_w = 0; val_w = 0; inc_w = 0; bias_w = 0; ph_w = PH_RISE; pos_w = 0;
  endtask

  // Mostly a set followed by a run of ticks, so phases wrap and retargets land
  // mid-phase; short or empty runs give back-to-back sets.
  task automatic queue_random(int count);
    int left, burst, d, n, last_d, last_n;
    left   = count;
    last_d = 0;
    last_n = 0;
    while (left > 0) begin
      case ($urandom_range(0, 5))
        0: d = int'($urandom_range(0, 2000)) - 1000;
        1: case ($urandom_range(0, 4))
             0: d = -(1 << 30);
             1: d = (1 << 30) - 1;
             2: d = -1;
             3: d = 0;
             default: d = 1;
           endcase
        2, 3: d = int'(31'($urandom()));
        4: d = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 65536));
        default: d = last_d;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: n = $urandom_range(1, 24);
        4: n = 0;
        5: n = $urandom_range(25, 4096);
        6: n = int'(24'($urandom()));
        7: n = $urandom_range(MAX_STEPS - 8, MAX_STEPS + 8);
        8: n = $urandom_range(0, 1) ? 24'hFF_FFFF : MAX_STEPS;
        default: n = last_n;
      endcase
      // whole repeat of the previous set: the no-change case
      if ($urandom_range(0, 7) == 0) begin
        d = last_d;
        n = last_n;
      end
      push_set(d, n);
      last_d = 31'(d);
      last_n = n;
      left--;
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      while (burst > 0 && left > 0) begin
        push_tick();
        burst--;
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit [30:0] mv_list[7];
    mv_list[0] = 31'd0;
    mv_list[1] = 31'd1;                  // deepest value shift
    mv_list[2] = 31'h4000_0000;          // max_value of 2^30, no shift
    mv_list[3] = 31'd2;
    mv_list[4] = 31'((1 << 20) + 1);
    mv_list[5] = 31'd65535;
    mv_list[6] = 31'($urandom_range(0, 32'h4000_0000));
    shift_w = 0;
    amp_w = 0; len_w = 0; val_w = 0; inc_w = 0; bias_w = 0; ph_w = PH_RISE; pos_w = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, sender 29% / receiver 45% idle.
    program_max(31'(1 << 20));
    push_tick();                          // tick with no phase length
    push_set(100, 4);
    repeat (5) push_tick();               // wraps past the first quarter
    push_set(100, 4);                     // same target: no change
    push_set(-(1 << 30), 3);              // retarget mid-phase, most negative delta
    push_tick();
    push_set((1 << 30) - 1, 24'hFF_FFFF); // largest delta, steps clamped
    push_set(-1, MAX_STEPS);              // bias divide hits most negative / -1
    push_set(0, 5);                       // zero amplitude: bias cleared
    push_set(100, 100);                   // nonzero bias
    push_set(77, 0);                      // clear, bias kept
    push_tick();
    push_set(50, 1);                      // one step per phase
    repeat (4) push_tick();
    push_set(-300, MAX_STEPS + 1);        // just past the clamp
    push_tick();
    settle(0);

    // Random blocks, one max_value each.
    for (int k = 0; k < 7; k++) begin
      program_max(mv_list[k]);
      if (k == 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 29;
      end else if (k == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_random(RAND_ITEMS);
      // stall the output while the input keeps coming
      if (k == 3 || k == 5) -> hold_go;
      settle(0);
    end

    settle(TAIL);
    if (err_cnt == 0 && level_q.size() == 0)
      $display("triangle_oscillator_retarget verification clean");
    else
      $display("triangle_oscillator_retarget verification failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/tosc_pkg.sv
sv/tosc_div.sv
sv/triangle_oscillator_retarget.sv
verif/triangle_oscillator_retarget_tb.sv
